### rtl/totp_pkg.sv
// Shared types, constants and SHA-1 helpers for the TOTP generate/verify unit.
// No dependencies.
`default_nettype none
package totp_pkg;

  typedef struct packed {
    logic [63:0] unix_seconds;
    logic [29:0] user_code;
  } totp_in_t;

  typedef struct packed {
    logic [29:0] current_code;
    logic        code_matched;
    logic        key_too_short;
  } totp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_LOAD, ST_HASH, ST_ADD, ST_TRUNC, ST_MOD, ST_CMP, ST_DONE
  } totp_state_t;

  // Which compression the shared SHA-1 round unit is running
  typedef enum logic [1:0] {
    JOB_KEYI, JOB_KEYO, JOB_INNER, JOB_OUTER
  } totp_job_t;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_KEYLEN = 3'd4;
  localparam logic [2:0] REG_DIGITS = 3'd5;
  localparam logic [2:0] REG_WINDOW = 3'd6;

  localparam logic [5:0]   MIN_KEY_BYTES = 6'd16;
  localparam logic [159:0] SHA1_H0 =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [7:0]   IPAD = 8'h36;
  localparam logic [7:0]   OPAD = 8'h5C;
  localparam logic [63:0]  INNER_BITS = 64'd576;
  localparam logic [63:0]  OUTER_BITS = 64'd672;

  function automatic logic [29:0] pow_ten(input logic [3:0] d);
    logic [29:0] p;
    unique case (d)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

  // One SHA-1 round on {a,b,c,d,e}
  function automatic logic [159:0] sha1_round(input logic [159:0] s,
                                              input logic [31:0] wt,
                                              input logic [6:0] rnd);
    logic [31:0] a, b, c, d, e, f, k, t;
    a = s[159:128]; b = s[127:96]; c = s[95:64]; d = s[63:32]; e = s[31:0];
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5A827999;
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ED9EBA1;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d; k = 32'hCA62C1D6;
    end
    t = {a[26:0], a[31:27]} + f + e + k + wt;
    return {t, a, {b[1:0], b[31:2]}, c, d};
  endfunction

endpackage
`default_nettype wire

### rtl/totp_generate_verify_unit.sv
// Top level of the TOTP (HMAC-SHA1) generate/verify unit.
// Depends on totp_pkg.
`default_nettype none
// Usage: write the key, key length, digit count and window through the
// cfg_we/cfg_index/cfg_data port while the unit is idle. Issue a command word
// (time in seconds and the user's code) by raising start while busy is low.
// busy stays high until the result word appears on result with done high for
// exactly one cycle; the receiver cannot stall, so take it in that cycle.
// Sequence: a short key goes straight to the result. Otherwise the time is
// divided by the step (long division, one 16-bit digit at a time), then come
// two key-pad compressions, then for each of 2*window+1 steps two
// compressions, a truncate, a modulo and a compare, all on one SHA-1 round
// unit at one round per cycle. The SHA-1 round unit sets the rate.
// Reset returns the unit to idle and loads the register defaults: key zero,
// key length 0, six digits, window 1.
module totp_generate_verify_unit #(
  parameter int MAX_KEY_BYTES = 32,
  parameter int MAX_WINDOW    = 7,
  parameter int STEP_SECONDS  = 30
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  wire totp_pkg::totp_in_t cmd,
  output logic                   done,
  output totp_pkg::totp_out_t    result,
  input  wire                    cfg_we,
  input  wire  [2:0]             cfg_index,
  input  wire  [63:0]            cfg_data
);

  // reciprocal of the step, exact for every 28-bit partial dividend
  localparam int STEP_BITS = $clog2(STEP_SECONDS);
  localparam int RSH = 28 + STEP_BITS;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RSH) + 64'(STEP_SECONDS) - 64'd1) / 64'(STEP_SECONDS);
  localparam logic [28:0] RECIP = RECIP_FULL[28:0];
  localparam logic [11:0] STEP = 12'(STEP_SECONDS);
  localparam logic [6:0]    KEY_CAP = 7'(MAX_KEY_BYTES);
  localparam logic [3:0]    WIN_CAP = 4'(MAX_WINDOW);

  // configuration
  logic [255:0] key;
  logic [5:0]   key_length;
  logic [3:0]   code_digits;
  logic [2:0]   window_steps;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      key_length <= '0;
      code_digits <= 4'd6;
      window_steps <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        totp_pkg::REG_KEY0:   key[255:192] <= cfg_data;
        totp_pkg::REG_KEY1:   key[191:128] <= cfg_data;
        totp_pkg::REG_KEY2:   key[127:64]  <= cfg_data;
        totp_pkg::REG_KEY3:   key[63:0]    <= cfg_data;
        totp_pkg::REG_KEYLEN: key_length   <= cfg_data[5:0];
        totp_pkg::REG_DIGITS: code_digits  <= cfg_data[3:0];
        totp_pkg::REG_WINDOW: window_steps <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [6:0]  klen;
  logic [3:0]  digits;
  logic [3:0]  win;
  logic [29:0] modulus;

  always_comb begin
    klen = ({1'b0, key_length} > KEY_CAP) ? KEY_CAP : {1'b0, key_length};
    digits = (code_digits > 4'd9) ? 4'd9 : code_digits;
    win = ({1'b0, window_steps} > WIN_CAP) ? WIN_CAP : {1'b0, window_steps};
    modulus = totp_pkg::pow_ten(digits);
  end

  // sequencer and datapath registers
  totp_pkg::totp_state_t state, state_next;
  totp_pkg::totp_job_t   job;
  logic [63:0]  dvd;        // time, then quotient = current counter
  logic [11:0]  drem;
  logic [15:0]  dq;
  logic [6:0]   cnt;
  logic [63:0]  ctr;        // counter under test
  logic [4:0]   idx;
  logic [29:0]  user;
  logic [159:0] hs;         // a..e
  logic [15:0][31:0] wq;    // message schedule window, wq[0] is w[t]
  logic [159:0] istate, ostate, idig, dig;
  logic [30:0]  mdvd;
  logic [30:0]  mrem;
  logic         matched;

  // key block with pad
  logic [511:0] key_blk;
  logic [7:0]   pad;
  always_comb begin
    pad = (job == totp_pkg::JOB_KEYI) ? totp_pkg::IPAD : totp_pkg::OPAD;
    for (int i = 0; i < 32; i++) begin
      if (7'(i) < klen) begin
        key_blk[511-8*i -: 8] = key[255-8*i -: 8] ^ pad;
      end else begin
        key_blk[511-8*i -: 8] = pad;
      end
    end
    for (int i = 32; i < 64; i++) begin
      key_blk[511-8*i -: 8] = pad;
    end
  end

  logic [511:0] blk;
  logic [159:0] hin;
  always_comb begin
    unique case (job)
      totp_pkg::JOB_KEYI, totp_pkg::JOB_KEYO: begin
        blk = key_blk; hin = totp_pkg::SHA1_H0;
      end
      totp_pkg::JOB_INNER: begin
        blk = {ctr, 8'h80, 376'd0, totp_pkg::INNER_BITS}; hin = istate;
      end
      default: begin
        blk = {idig, 8'h80, 280'd0, totp_pkg::OUTER_BITS}; hin = ostate;
      end
    endcase
  end

  logic [159:0] hout;
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      hout[159-32*i -: 32] = hin[159-32*i -: 32] + hs[159-32*i -: 32];
    end
  end

  logic [27:0]   dx;
  logic [56:0]   dprod;
  logic [27:0]   dqs;
  logic [30:0]   msh;
  logic [31:0]   wnew;
  logic [319:0]  dshift;
  logic [30:0]   bin;
  always_comb begin
    dx = {drem, dvd[63:48]};
    dprod = 57'(dx) * 57'(RECIP);
    dqs = 28'(dq) * 28'(STEP);
    msh = {mrem[29:0], mdvd[30]};
    wnew = wq[13] ^ wq[8] ^ wq[2] ^ wq[0];
    wnew = {wnew[30:0], wnew[31]};
    dshift = {dig, 160'd0} << {dig[3:0], 3'b000};
    bin = dshift[318:288];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      totp_pkg::ST_IDLE:
        if (start) begin
          state_next = (key_length < totp_pkg::MIN_KEY_BYTES) ? totp_pkg::ST_DONE
                                                               : totp_pkg::ST_DIV;
        end
      totp_pkg::ST_DIV:   if (cnt == 7'd7) state_next = totp_pkg::ST_LOAD;
      totp_pkg::ST_LOAD:  state_next = totp_pkg::ST_HASH;
      totp_pkg::ST_HASH:  if (cnt == 7'd79) state_next = totp_pkg::ST_ADD;
      totp_pkg::ST_ADD:
        state_next = (job == totp_pkg::JOB_OUTER) ? totp_pkg::ST_TRUNC : totp_pkg::ST_LOAD;
      totp_pkg::ST_TRUNC: state_next = totp_pkg::ST_MOD;
      totp_pkg::ST_MOD:   if (cnt == 7'd30) state_next = totp_pkg::ST_CMP;
      totp_pkg::ST_CMP:
        state_next = (idx == {win, 1'b0}) ? totp_pkg::ST_DONE : totp_pkg::ST_LOAD;
      totp_pkg::ST_DONE:  state_next = totp_pkg::ST_IDLE;
      default:            state_next = totp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != totp_pkg::ST_IDLE);
    done = (state == totp_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= totp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      totp_pkg::ST_IDLE: begin
        dvd <= cmd.unix_seconds;
        user <= cmd.user_code;
        drem <= '0;
        cnt <= '0;
        job <= totp_pkg::JOB_KEYI;
        matched <= 1'b0;
        result <= {30'd0, 1'b0, (key_length < totp_pkg::MIN_KEY_BYTES)};
      end
      totp_pkg::ST_DIV: begin
        // long division by the step, one 16-bit digit at a time:
        // estimate the digit by reciprocal multiply, then subtract
        if (!cnt[0]) begin
          dq <= dprod[RSH +: 16];
        end else begin
          drem <= dx[11:0] - dqs[11:0];
          dvd <= {dvd[47:0], dq};
        end
        cnt <= cnt + 7'd1;
      end
      totp_pkg::ST_LOAD: begin
        hs <= hin;
        for (int i = 0; i < 16; i++) wq[i] <= blk[511-32*i -: 32];
        cnt <= '0;
      end
      totp_pkg::ST_HASH: begin
        hs <= totp_pkg::sha1_round(hs, wq[0], cnt);
        for (int i = 0; i < 15; i++) wq[i] <= wq[i+1];
        wq[15] <= wnew;
        cnt <= cnt + 7'd1;
      end
      totp_pkg::ST_ADD: begin
        unique case (job)
          totp_pkg::JOB_KEYI: begin
            istate <= hout; job <= totp_pkg::JOB_KEYO;
          end
          totp_pkg::JOB_KEYO: begin
            ostate <= hout; job <= totp_pkg::JOB_INNER;
            ctr <= dvd - {60'd0, win};
            idx <= '0;
          end
          totp_pkg::JOB_INNER: begin
            idig <= hout; job <= totp_pkg::JOB_OUTER;
          end
          default: dig <= hout;
        endcase
      end
      totp_pkg::ST_TRUNC: begin
        mdvd <= bin;
        mrem <= '0;
        cnt <= '0;
      end
      totp_pkg::ST_MOD: begin
        // restoring remainder by ten to the digits
        if (msh >= {1'b0, modulus}) begin
          mrem <= msh - {1'b0, modulus};
        end else begin
          mrem <= msh;
        end
        mdvd <= {mdvd[29:0], 1'b0};
        cnt <= cnt + 7'd1;
      end
      totp_pkg::ST_CMP: begin
        if (mrem[29:0] == user) matched <= 1'b1;
        // the running match lands in the result; the last step leaves it final
        result <= {(ctr == dvd) ? mrem[29:0] : result.current_code,
                   matched || (mrem[29:0] == user), 1'b0};
        ctr <= ctr + 64'd1;
        idx <= idx + 5'd1;
        job <= totp_pkg::JOB_INNER;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");
  a_short_key_result: assert property (@(posedge clk) disable iff (rst)
    (done && result.key_too_short) |-> (result.current_code == '0 && !result.code_matched))
    else $error("short key gave a code");
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state == totp_pkg::ST_HASH) |-> (cnt < 7'd80)) else $error("round overrun");
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    (state == totp_pkg::ST_CMP) |-> (mrem < {1'b0, modulus})) else $error("bad remainder");
`endif

endmodule
`default_nettype wire

### test/totp_generate_verify_unit_tb.sv
// Self-checking testbench for the TOTP (HMAC-SHA1) generate/verify unit.
// Depends on totp_pkg and totp_generate_verify_unit; carries its own SHA-1/HMAC predictor.
module totp_generate_verify_unit_tb;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum int {ROW_WRITE, ROW_FIXED, ROW_PREDICT, ROW_HIT} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [63:0] seconds;
    logic [29:0] user;
    int          off;
    totp_pkg::totp_out_t want;
  } row_t;

  localparam totp_pkg::totp_out_t SHORT_KEY = {30'd0, 1'b0, 1'b1};
  localparam totp_pkg::totp_out_t NONE      = {30'd0, 1'b0, 1'b0};
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [2:0] K0 = totp_pkg::REG_KEY0;
  localparam logic [2:0] KL = totp_pkg::REG_KEYLEN;
  localparam logic [2:0] DG = totp_pkg::REG_DIGITS;
  localparam logic [2:0] WN = totp_pkg::REG_WINDOW;

  localparam int N_ROWS = 30;
  row_t dir_rows [N_ROWS] = '{
    '{ROW_FIXED,   K0,         64'd0, 64'd0, 30'd0, 0, SHORT_KEY},
    '{ROW_FIXED,   K0,         64'd0, '1, 30'd999999999, 0, SHORT_KEY},
    '{ROW_WRITE,   REG_UNUSED, '1, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   totp_pkg::REG_KEY0, 64'h3132333435363738, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   totp_pkg::REG_KEY1, 64'h3930313233343536, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   totp_pkg::REG_KEY2, 64'h373839303132FFFF, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   totp_pkg::REG_KEY3, 64'hFFFFFFFFFFFFFFFF, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   KL,         64'd15, 64'd0, 30'd0, 0, NONE},
    '{ROW_FIXED,   K0,         64'd0, 64'd59, 30'd123, 0, SHORT_KEY},
    '{ROW_WRITE,   KL,         64'd16, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   WN,         64'd0, 64'd0, 30'd0, 0, NONE},
    '{ROW_HIT,     K0,         64'd0, 64'd0, 30'd0, 0, NONE},
    '{ROW_PREDICT, K0,         64'd0, '1, 30'd0, 0, NONE},
    '{ROW_WRITE,   KL,         64'd32, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   DG,         64'd9, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   WN,         64'd7, 64'd0, 30'd0, 0, NONE},
    '{ROW_HIT,     K0,         64'd0, 64'd59, 30'd0, -7, NONE},
    '{ROW_HIT,     K0,         64'd0, 64'd1234567890, 30'd0, 7, NONE},
    '{ROW_PREDICT, K0,         64'd0, 64'd90, 30'd999999999, 0, NONE},
    '{ROW_WRITE,   KL,         64'd63, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   DG,         64'd15, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   WN,         64'd3, 64'd0, 30'd0, 0, NONE},
    '{ROW_HIT,     K0,         64'd0, 64'd1111111109, 30'd0, 3, NONE},
    '{ROW_HIT,     K0,         64'd0, 64'd2000000000, 30'd0, -4, NONE},
    '{ROW_WRITE,   DG,         64'd0, 64'd0, 30'd0, 0, NONE},
    '{ROW_PREDICT, K0,         64'd0, 64'd30, 30'd0, 0, NONE},
    '{ROW_WRITE,   DG,         64'd1, 64'd0, 30'd0, 0, NONE},
    '{ROW_WRITE,   KL,         64'd20, 64'd0, 30'd0, 0, NONE},
    '{ROW_HIT,     K0,         64'd0, '1, 30'd0, -1, NONE},
    '{ROW_PREDICT, K0,         64'd0, 64'h8000000000000000, 30'd5, 0, NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  totp_pkg::totp_in_t  cmd = '0;
  logic        done;
  totp_pkg::totp_out_t result;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  totp_generate_verify_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register mirror used by the predictor
  logic [63:0] key_word [4];
  logic [5:0]  key_len;
  logic [3:0]  digits;
  logic [2:0]  window;

  totp_pkg::totp_out_t pending_words [$];
  int        mismatches = 0;
  int        idle_pct = 0;
  int        quiet_cycles = 0;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                 input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = h;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  // SHA-1 of a message that fits two blocks; first byte in the top bits
  function automatic logic [159:0] sha1_two(input logic [1023:0] msg, input int len);
    logic [1023:0] buf_m;
    logic [159:0]  h;
    buf_m = msg;
    buf_m[1023 - 8*len -: 8] = 8'h80;
    buf_m[63:0] = 64'(len * 8);
    h = sha1_compress(160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0, buf_m[1023:512]);
    return sha1_compress(h, buf_m[511:0]);
  endfunction

  function automatic logic [29:0] totp_code(input logic [63:0] counter);
    logic [1023:0] ibuf, obuf;
    logic [159:0]  dig;
    logic [7:0]    kb;
    logic [31:0]   bin;
    int            klen, nd, off;
    longint unsigned modulus;
    klen = (key_len > 32) ? 32 : int'(key_len);
    nd   = (digits > 9) ? 9 : int'(digits);
    modulus = 1;
    for (int i = 0; i < nd; i++) modulus = modulus * 10;
    ibuf = '0;
    obuf = '0;
    for (int i = 0; i < 64; i++) begin
      kb = (i < klen) ? key_word[i/8][63 - 8*(i%8) -: 8] : 8'h00;
      ibuf[1023 - 8*i -: 8] = kb ^ 8'h36;
      obuf[1023 - 8*i -: 8] = kb ^ 8'h5C;
    end
    ibuf[1023 - 512 -: 64] = counter;
    dig = sha1_two(ibuf, 72);
    obuf[1023 - 512 -: 160] = dig;
    dig = sha1_two(obuf, 84);
    off = int'(dig[3:0]);
    bin = dig[159 - 8*off -: 32] & 32'h7FFFFFFF;
    return 30'(longint'(bin) % modulus);
  endfunction

  function automatic totp_pkg::totp_out_t predict_word(input totp_pkg::totp_in_t c);
    totp_pkg::totp_out_t r;
    logic [63:0] ctr;
    int          w;
    if (key_len < 16) return SHORT_KEY;
    w   = int'(window);
    ctr = c.unix_seconds / 64'd30;
    r   = NONE;
    r.current_code = totp_code(ctr);
    for (int j = -w; j <= w; j++)
      if ((j == 0 ? r.current_code : totp_code(ctr + 64'(j))) == c.user_code)
        r.code_matched = 1'b1;
    return r;
  endfunction

  // Code that the block should see as offered at step counter+off
  function automatic logic [29:0] code_at_offset(input logic [63:0] seconds, input int off);
    return totp_code(seconds / 64'd30 + 64'(off));
  endfunction

  // When cfg_we is low, drop start and hold until the unit has drained
  task automatic wait_idle();
    if (!cfg_we) begin
      start <= 1'b0;
      while (pending_words.size() != 0 || busy) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end
  endtask

  // Leaves cfg_we high; the next command word lowers it
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      totp_pkg::REG_KEY0, totp_pkg::REG_KEY1, totp_pkg::REG_KEY2, totp_pkg::REG_KEY3:
        key_word[idx] = data;
      totp_pkg::REG_KEYLEN: key_len = data[5:0];
      totp_pkg::REG_DIGITS: digits = data[3:0];
      totp_pkg::REG_WINDOW: window = data[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic issue(input totp_pkg::totp_in_t c, input totp_pkg::totp_out_t want,
                       input bit typed);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pending_words.push_back(typed ? want : predict_word(c));
  endtask

  // Result checking and watchdog
  always @(posedge clk) begin
    totp_pkg::totp_out_t exp_w;
    if (!rst) begin
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog expired with %0d words pending", pending_words.size());
        $display("TB_ERROR");
        $finish;
      end
      if (done) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", result);
        end else begin
          exp_w = pending_words.pop_front();
          if (result.current_code !== exp_w.current_code ||
              result.code_matched !== exp_w.code_matched ||
              result.key_too_short !== exp_w.key_too_short) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: code %0d/%0d matched %b/%b short %b/%b (exp/act)",
                       exp_w.current_code, result.current_code, exp_w.code_matched,
                       result.code_matched, exp_w.key_too_short, result.key_too_short);
          end
        end
      end
    end
  end

  initial begin
    totp_pkg::totp_in_t c;
    int       w, pick;
    int       phase_idle [6];
    phase_idle = '{0, 45, 17, 45, 0, 17};
    for (int i = 0; i < 4; i++) key_word[i] = '0;
    key_len = '0;
    digits = 4'd6;
    window = 3'd1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      c.unix_seconds = dir_rows[i].seconds;
      c.user_code    = dir_rows[i].user;
      case (dir_rows[i].kind)
        ROW_WRITE: write_reg(dir_rows[i].idx, dir_rows[i].data);
        ROW_FIXED: issue(c, dir_rows[i].want, 1'b1);
        ROW_PREDICT: issue(c, NONE, 1'b0);
        default: begin
          c.user_code = code_at_offset(c.unix_seconds, dir_rows[i].off);
          issue(c, NONE, 1'b0);
        end
      endcase
    end

    for (int p = 0; p < 6; p++) begin
      idle_pct = 0;
      for (int i = 0; i < 4; i++) write_reg(3'(i), {$urandom, $urandom});
      case (p)
        2: write_reg(totp_pkg::REG_KEYLEN, 64'($urandom_range(0, 15)));
        4: write_reg(totp_pkg::REG_KEYLEN, 64'($urandom_range(33, 63)));
        default: write_reg(totp_pkg::REG_KEYLEN, 64'($urandom_range(16, 32)));
      endcase
      write_reg(totp_pkg::REG_DIGITS, 64'($urandom_range(0, 15)));
      write_reg(totp_pkg::REG_WINDOW, (p == 5) ? 64'd7 : 64'($urandom_range(0, 2)));
      idle_pct = phase_idle[p];
      for (int n = 0; n < 20; n++) begin
        // Hold off until the unit has drained
        if (p == 1 && n == 10) begin
          start <= 1'b0;
          @(posedge clk);
          while (pending_words.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(3);
        case (pick)
          0: c.unix_seconds = {$urandom, $urandom};
          1: c.unix_seconds = 64'($urandom_range(0, 300));
          2: c.unix_seconds = ~64'($urandom_range(0, 300));
          default: c.unix_seconds = {32'd0, $urandom};
        endcase
        w = int'(window);
        if ($urandom_range(1)) begin
          c.user_code = (key_len < 16) ? 30'($urandom_range(0, 999999999))
                      : code_at_offset(c.unix_seconds, $urandom_range(0, 2*w + 2) - w - 1);
        end else begin
          c.user_code = 30'($urandom_range(0, 999999999));
        end
        issue(c, NONE, 1'b0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
